// ===== hw/rtl/strb_pkg.sv =====
// Shared types, tables and functions of the Streebog hash engine.
// Holds the S-box, the linear map rows, the round constants and the LPS transform.
// Depends on nothing.
`timescale 1ns / 1ps
package strb_pkg;

  localparam int Rounds = 12;

  typedef struct packed {
    logic [63:0] data_word;
    logic        end_of_block;
    logic        final_block;
    logic [8:0]  tail_bits;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } out_t;

  typedef enum logic [1:0] {
    SEL_BLOCK = 2'd0,
    SEL_COUNT = 2'd1,
    SEL_SUM   = 2'd2
  } sel_t;

  typedef struct packed {
    logic       load_word;
    logic       init;
    logic       round;
    logic       fold;
    logic       update;
    logic       restart;
    sel_t       sel;
    logic [3:0] rnd;
    logic [2:0] oidx;
  } cmd_t;

  localparam logic [511:0] IV_256 = {64{8'h01}};

  localparam logic [7:0] SBOX [256] = '{
    252, 238, 221, 17, 207, 110, 49, 22, 251, 196, 250, 218, 35, 197, 4, 77,
    233, 119, 240, 219, 147, 46, 153, 186, 23, 54, 241, 187, 20, 205, 95, 193,
    249, 24, 101, 90, 226, 92, 239, 33, 129, 28, 60, 66, 139, 1, 142, 79,
    5, 132, 2, 174, 227, 106, 143, 160, 6, 11, 237, 152, 127, 212, 211, 31,
    235, 52, 44, 81, 234, 200, 72, 171, 242, 42, 104, 162, 253, 58, 206, 204,
    181, 112, 14, 86, 8, 12, 118, 18, 191, 114, 19, 71, 156, 183, 93, 135,
    21, 161, 150, 41, 16, 123, 154, 199, 243, 145, 120, 111, 157, 158, 178, 177,
    50, 117, 25, 61, 255, 53, 138, 126, 109, 84, 198, 128, 195, 189, 13, 87,
    223, 245, 36, 169, 62, 168, 67, 201, 215, 121, 214, 246, 124, 34, 185, 3,
    224, 15, 236, 222, 122, 148, 176, 188, 220, 232, 40, 80, 78, 51, 10, 74,
    167, 151, 96, 115, 30, 0, 98, 68, 26, 184, 56, 130, 100, 159, 38, 65,
    173, 69, 70, 146, 39, 94, 85, 47, 140, 163, 165, 125, 105, 213, 149, 59,
    7, 88, 179, 64, 134, 172, 29, 247, 48, 55, 107, 228, 136, 217, 231, 137,
    225, 27, 131, 73, 76, 63, 248, 254, 141, 83, 170, 144, 202, 216, 133, 97,
    32, 113, 103, 164, 45, 43, 9, 91, 203, 155, 37, 208, 190, 229, 108, 82,
    89, 166, 116, 210, 230, 244, 180, 192, 209, 102, 175, 194, 57, 75, 99, 182
  };

  localparam logic [63:0] LIN [64] = '{
    64'h8e20faa72ba0b470, 64'h47107ddd9b505a38, 64'had08b0e0c3282d1c, 64'hd8045870ef14980e,
    64'h6c022c38f90a4c07, 64'h3601161cf205268d, 64'h1b8e0b0e798c13c8, 64'h83478b07b2468764,
    64'ha011d380818e8f40, 64'h5086e740ce47c920, 64'h2843fd2067adea10, 64'h14aff010bdd87508,
    64'h0ad97808d06cb404, 64'h05e23c0468365a02, 64'h8c711e02341b2d01, 64'h46b60f011a83988e,
    64'h90dab52a387ae76f, 64'h486dd4151c3dfdb9, 64'h24b86a840e90f0d2, 64'h125c354207487869,
    64'h092e94218d243cba, 64'h8a174a9ec8121e5d, 64'h4585254f64090fa0, 64'haccc9ca9328a8950,
    64'h9d4df05d5f661451, 64'hc0a878a0a1330aa6, 64'h60543c50de970553, 64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd, 64'h0c84890ad27623e0, 64'h0642ca05693b9f70, 64'h0321658cba93c138,
    64'h86275df09ce8aaa8, 64'h439da0784e745554, 64'hafc0503c273aa42a, 64'hd960281e9d1d5215,
    64'he230140fc0802984, 64'h71180a8960409a42, 64'hb60c05ca30204d21, 64'h5b068c651810a89e,
    64'h456c34887a3805b9, 64'hac361a443d1c8cd2, 64'h561b0d22900e4669, 64'h2b838811480723ba,
    64'h9bcf4486248d9f5d, 64'hc3e9224312c8c1a0, 64'heffa11af0964ee50, 64'hf97d86d98a327728,
    64'he4fa2054a80b329c, 64'h727d102a548b194e, 64'h39b008152acb8227, 64'h9258048415eb419d,
    64'h492c024284fbaec0, 64'haa16012142f35760, 64'h550b8e9e21f7a530, 64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e, 64'h3853dc371220a247, 64'h1ca76e95091051ad, 64'h0edd37c48a08a6d8,
    64'h07e095624504536c, 64'h8d70c431ac02a736, 64'hc83862965601dd1b, 64'h641c314b2b8ee083
  };

  // Round constants with the most significant word first.
  function automatic logic [511:0] round_const(input logic [3:0] r);
    logic [511:0] c;
    case (r)
      4'd0: c = {64'hb1085bda1ecadae9, 64'hebcb2f81c0657c1f, 64'h2f6a76432e45d016,
                 64'h714eb88d7585c4fc, 64'h4b7ce09192676901, 64'ha2422a08a460d315,
                 64'h05767436cc744d23, 64'hdd806559f2a64507};
      4'd1: c = {64'h6fa3b58aa99d2f1a, 64'h4fe39d460f70b5d7, 64'hf3feea720a232b98,
                 64'h61d55e0f16b50131, 64'h9ab5176b12d69958, 64'h5cb561c2db0aa7ca,
                 64'h55dda21bd7cbcd56, 64'he679047021b19bb7};
      4'd2: c = {64'hf574dcac2bce2fc7, 64'h0a39fc286a3d8435, 64'h06f15e5f529c1f8b,
                 64'hf2ea7514b1297b7b, 64'hd3e20fe490359eb1, 64'hc1c93a376062db09,
                 64'hc2b6f443867adb31, 64'h991e96f50aba0ab2};
      4'd3: c = {64'hef1fdfb3e81566d2, 64'hf948e1a05d71e4dd, 64'h488e857e335c3c7d,
                 64'h9d721cad685e353f, 64'ha9d72c82ed03d675, 64'hd8b71333935203be,
                 64'h3453eaa193e837f1, 64'h220cbebc84e3d12e};
      4'd4: c = {64'h4bea6bacad474799, 64'h9a3f410c6ca92363, 64'h7f151c1f1686104a,
                 64'h359e35d7800fffbd, 64'hbfcd1747253af5a3, 64'hdfff00b723271a16,
                 64'h7a56a27ea9ea63f5, 64'h601758fd7c6cfe57};
      4'd5: c = {64'hae4faeae1d3ad3d9, 64'h6fa4c33b7a3039c0, 64'h2d66c4f95142a46c,
                 64'h187f9ab49af08ec6, 64'hcffaa6b71c9ab7b4, 64'h0af21f66c2bec6b6,
                 64'hbf71c57236904f35, 64'hfa68407a46647d6e};
      4'd6: c = {64'hf4c70e16eeaac5ec, 64'h51ac86febf240954, 64'h399ec6c7e6bf87c9,
                 64'hd3473e33197a93c9, 64'h0992abc52d822c37, 64'h06476983284a0504,
                 64'h3517454ca23c4af3, 64'h8886564d3a14d493};
      4'd7: c = {64'h9b1f5b424d93c9a7, 64'h03e7aa020c6e4141, 64'h4eb7f8719c36de1e,
                 64'h89b4443b4ddbc49a, 64'hf4892bcb929b0690, 64'h69d18d2bd1a5c42f,
                 64'h36acc2355951a8d9, 64'ha47f0dd4bf02e71e};
      4'd8: c = {64'h378f5a541631229b, 64'h944c9ad8ec165fde, 64'h3a7d3a1b25894224,
                 64'h3cd955b7e00d0984, 64'h800a440bdbb2ceb1, 64'h7b2b8a9aa6079c54,
                 64'h0e38dc92cb1f2a60, 64'h7261445183235adb};
      4'd9: c = {64'habbedea680056f52, 64'h382ae548b2e4f3f3, 64'h8941e71cff8a78db,
                 64'h1fffe18a1b336103, 64'h9fe76702af69334b, 64'h7a1e6c303b7652f4,
                 64'h3698fad1153bb6c3, 64'h74b4c7fb98459ced};
      4'd10: c = {64'h7bcd9ed0efc889fb, 64'h3002c6cd635afe94, 64'hd8fa6bbbebab0761,
                  64'h2001802114846679, 64'h8a1d71efea48b9ca, 64'hefbacd1d7d476e98,
                  64'hdea2594ac06fd85d, 64'h6bcaa4cd81f32d1b};
      4'd11: c = {64'h378ee767f11631ba, 64'hd21380b00449b17a, 64'hcda43c32bcdf1d77,
                  64'hf82012d430219f9b, 64'h5d80ef9d1891cc86, 64'he71da4aa88e12852,
                  64'hfaf417d5d9b21b99, 64'h48bc924af11bd720};
      default: c = '0;
    endcase
    return c;
  endfunction

  // Substitution, byte transposition and linear map; word 0 is most significant.
  function automatic logic [511:0] lps(input logic [511:0] x);
    logic [511:0] t;
    logic [511:0] y;
    logic [63:0]  v;
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 8; k++) begin
        t[511 - 64 * i - 8 * k -: 8] = SBOX[x[511 - 64 * k - 8 * i -: 8]];
      end
    end
    for (int i = 0; i < 8; i++) begin
      v = '0;
      for (int b = 0; b < 64; b++) begin
        if (t[511 - 64 * i - b]) begin
          v = v ^ LIN[b];
        end
      end
      y[511 - 64 * i -: 64] = v;
    end
    return y;
  endfunction

endpackage

// ===== hw/rtl/strb_datapath.sv =====
// Datapath of the Streebog hash engine: block assembly, compression rounds,
// counter and checksum sums, digest word selection. Depends on strb_pkg.
`timescale 1ns / 1ps
module strb_datapath
  import strb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  cmd_t        cmd,
  input  in_t         in_data,
  output out_t        out_data
);

  logic         d512;
  logic [511:0] h;
  logic [511:0] cnt;
  logic [511:0] sum;
  logic [63:0]  wbuf [8];
  logic [7:0]   wvld;
  logic [2:0]   widx;
  logic [511:0] blk;
  logic         fin;
  logic [8:0]   tb;
  logic [511:0] key;
  logic [511:0] st;
  logic [511:0] msg;

  logic [511:0] asm_blk;
  logic [511:0] pad_mask;
  logic [511:0] mval;
  logic [511:0] nval;
  logic [511:0] key0;
  logic [511:0] key_rnd;
  logic [9:0]   cnt_add;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (3'(i) == widx) begin
        asm_blk[511 - 64 * i -: 64] = in_data.data_word;
      end else if (wvld[i]) begin
        asm_blk[511 - 64 * i -: 64] = wbuf[i];
      end else begin
        asm_blk[511 - 64 * i -: 64] = '0;
      end
    end
  end

  assign pad_mask = {512{1'b1}} << in_data.tail_bits;

  always_comb begin
    case (cmd.sel)
      SEL_BLOCK: begin
        mval = blk;
        nval = cnt;
      end
      SEL_COUNT: begin
        mval = cnt;
        nval = '0;
      end
      SEL_SUM: begin
        mval = sum;
        nval = '0;
      end
      default: begin
        mval = blk;
        nval = cnt;
      end
    endcase
  end

  assign key0    = lps(h ^ nval);
  assign key_rnd = lps(key ^ round_const(cmd.rnd));
  assign cnt_add = fin ? {1'b0, tb} : 10'd512;

  always_ff @(posedge clk) begin
    if (rst) begin
      d512 <= 1'b1;
      h    <= '0;
      cnt  <= '0;
      sum  <= '0;
      wvld <= '0;
      widx <= '0;
    end else if (cfg_write || cmd.restart) begin
      if (cfg_write) begin
        d512 <= cfg_data;
      end
      h    <= (cfg_write ? cfg_data : d512) ? '0 : IV_256;
      cnt  <= '0;
      sum  <= '0;
      wvld <= '0;
      widx <= '0;
    end else begin
      if (cmd.load_word) begin
        if (in_data.end_of_block) begin
          wvld <= '0;
          widx <= '0;
        end else begin
          wvld[widx] <= 1'b1;
          widx       <= widx + 3'd1;
        end
      end
      if (cmd.fold) begin
        h <= h ^ st ^ msg;
      end
      if (cmd.update) begin
        cnt <= cnt + {502'd0, cnt_add};
        sum <= sum + blk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      wbuf[widx] <= in_data.data_word;
      if (in_data.end_of_block) begin
        fin <= in_data.final_block;
        tb  <= in_data.tail_bits;
        if (in_data.final_block) begin
          blk <= (asm_blk & ~pad_mask) | (512'd1 << in_data.tail_bits);
        end else begin
          blk <= asm_blk;
        end
      end
    end
    if (cmd.init) begin
      msg <= mval;
      key <= key0;
      st  <= mval ^ key0;
    end
    if (cmd.round) begin
      key <= key_rnd;
      st  <= lps(st) ^ key_rnd;
    end
  end

  assign out_data.digest_word = h[{3'd7 - cmd.oidx, 6'd0} +: 64];
  assign out_data.digest_last = (cmd.oidx == (d512 ? 3'd7 : 3'd3));

endmodule

// ===== hw/rtl/strb_ctrl.sv =====
// Controller of the Streebog hash engine: sequences word loading, the three
// compressions of a final block and digest output. Depends on strb_pkg.
`timescale 1ns / 1ps
module strb_ctrl
  import strb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  input  logic out_last,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROUND,
    S_FOLD,
    S_UPDATE,
    S_OUT
  } state_t;

  state_t     state;
  sel_t       sel;
  logic [3:0] rnd;
  logic [2:0] oidx;
  logic       fin;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.load_word = (state == S_IDLE) && in_valid;
    cmd.init      = (state == S_INIT);
    cmd.round     = (state == S_ROUND);
    cmd.fold      = (state == S_FOLD);
    cmd.update    = (state == S_UPDATE);
    cmd.restart   = (state == S_OUT) && !out_stall && out_last;
    cmd.sel       = sel;
    cmd.rnd       = rnd;
    cmd.oidx      = oidx;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      state <= S_IDLE;
      sel   <= SEL_BLOCK;
      rnd   <= '0;
      oidx  <= '0;
      fin   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_data.end_of_block) begin
            fin   <= in_data.final_block;
            sel   <= SEL_BLOCK;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (rnd == 4'(Rounds - 1)) begin
            state <= S_FOLD;
          end else begin
            rnd <= rnd + 4'd1;
          end
        end
        S_FOLD: begin
          case (sel)
            SEL_BLOCK: state <= S_UPDATE;
            SEL_COUNT: begin
              sel   <= SEL_SUM;
              state <= S_INIT;
            end
            default: begin
              oidx  <= '0;
              state <= S_OUT;
            end
          endcase
        end
        S_UPDATE: begin
          if (fin) begin
            sel   <= SEL_COUNT;
            state <= S_INIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/streebog_hash_engine_unit.sv =====
// Top level of the Streebog hash engine: joins controller and datapath.
// Depends on strb_pkg, strb_ctrl and strb_datapath.
//
// The input channel takes one 64-bit message word per beat; end_of_block
// marks the last word of a 512-bit block, and on that beat final_block and
// tail_bits describe the padded message tail. Words of a block are taken
// one per cycle. A block is then compressed (key setup, 12 rounds on two
// LPS units, a fold, then the counter and checksum add) while in_stall is
// high. A final block adds two more compressions, over the counter and then
// the checksum, and then the digest leaves on the output channel, one
// word per beat: 8 words for a 512-bit digest, 4 for a 256-bit digest,
// the last one flagged by digest_last. A stalled output word holds until
// taken. After the last digest beat the engine starts a new message.
// Reset selects the 512-bit digest and clears all message state. Writing
// cfg_data through cfg_write selects the digest size and restarts the
// message with the matching IV.
`timescale 1ns / 1ps
module streebog_hash_engine_unit
  import strb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t cmd;

  strb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_last  (out_data.digest_last),
    .cmd       (cmd)
  );

  strb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule

// ===== tb/streebog_hash_engine_unit_checker.sv =====
// Checker for the Streebog hash engine: watches the config port and both channels,
// predicts every digest word from the accepted message words and compares them.
// Depends on strb_pkg for the beat types, the S-box and the linear map rows.
`timescale 1ns / 1ps
module streebog_hash_engine_unit_checker
  import strb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_data,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  localparam logic [511:0] KEY_CONST [12] = '{
    {64'hb1085bda1ecadae9, 64'hebcb2f81c0657c1f, 64'h2f6a76432e45d016, 64'h714eb88d7585c4fc,
     64'h4b7ce09192676901, 64'ha2422a08a460d315, 64'h05767436cc744d23, 64'hdd806559f2a64507},
    {64'h6fa3b58aa99d2f1a, 64'h4fe39d460f70b5d7, 64'hf3feea720a232b98, 64'h61d55e0f16b50131,
     64'h9ab5176b12d69958, 64'h5cb561c2db0aa7ca, 64'h55dda21bd7cbcd56, 64'he679047021b19bb7},
    {64'hf574dcac2bce2fc7, 64'h0a39fc286a3d8435, 64'h06f15e5f529c1f8b, 64'hf2ea7514b1297b7b,
     64'hd3e20fe490359eb1, 64'hc1c93a376062db09, 64'hc2b6f443867adb31, 64'h991e96f50aba0ab2},
    {64'hef1fdfb3e81566d2, 64'hf948e1a05d71e4dd, 64'h488e857e335c3c7d, 64'h9d721cad685e353f,
     64'ha9d72c82ed03d675, 64'hd8b71333935203be, 64'h3453eaa193e837f1, 64'h220cbebc84e3d12e},
    {64'h4bea6bacad474799, 64'h9a3f410c6ca92363, 64'h7f151c1f1686104a, 64'h359e35d7800fffbd,
     64'hbfcd1747253af5a3, 64'hdfff00b723271a16, 64'h7a56a27ea9ea63f5, 64'h601758fd7c6cfe57},
    {64'hae4faeae1d3ad3d9, 64'h6fa4c33b7a3039c0, 64'h2d66c4f95142a46c, 64'h187f9ab49af08ec6,
     64'hcffaa6b71c9ab7b4, 64'h0af21f66c2bec6b6, 64'hbf71c57236904f35, 64'hfa68407a46647d6e},
    {64'hf4c70e16eeaac5ec, 64'h51ac86febf240954, 64'h399ec6c7e6bf87c9, 64'hd3473e33197a93c9,
     64'h0992abc52d822c37, 64'h06476983284a0504, 64'h3517454ca23c4af3, 64'h8886564d3a14d493},
    {64'h9b1f5b424d93c9a7, 64'h03e7aa020c6e4141, 64'h4eb7f8719c36de1e, 64'h89b4443b4ddbc49a,
     64'hf4892bcb929b0690, 64'h69d18d2bd1a5c42f, 64'h36acc2355951a8d9, 64'ha47f0dd4bf02e71e},
    {64'h378f5a541631229b, 64'h944c9ad8ec165fde, 64'h3a7d3a1b25894224, 64'h3cd955b7e00d0984,
     64'h800a440bdbb2ceb1, 64'h7b2b8a9aa6079c54, 64'h0e38dc92cb1f2a60, 64'h7261445183235adb},
    {64'habbedea680056f52, 64'h382ae548b2e4f3f3, 64'h8941e71cff8a78db, 64'h1fffe18a1b336103,
     64'h9fe76702af69334b, 64'h7a1e6c303b7652f4, 64'h3698fad1153bb6c3, 64'h74b4c7fb98459ced},
    {64'h7bcd9ed0efc889fb, 64'h3002c6cd635afe94, 64'hd8fa6bbbebab0761, 64'h2001802114846679,
     64'h8a1d71efea48b9ca, 64'hefbacd1d7d476e98, 64'hdea2594ac06fd85d, 64'h6bcaa4cd81f32d1b},
    {64'h378ee767f11631ba, 64'hd21380b00449b17a, 64'hcda43c32bcdf1d77, 64'hf82012d430219f9b,
     64'h5d80ef9d1891cc86, 64'he71da4aa88e12852, 64'hfaf417d5d9b21b99, 64'h48bc924af11bd720}
  };

  logic         wide_digest;
  logic [511:0] chain_h;
  logic [511:0] length_n;
  logic [511:0] sum_sigma;
  logic [63:0]  word_buf [8];
  logic [2:0]   word_pos;
  out_t         digest_queue [$];

  function automatic logic [511:0] mix_bytes(input logic [511:0] x);
    logic [511:0] t;
    logic [511:0] y;
    logic [63:0]  row;
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 8; k++) begin
        t[511 - 64 * i - 8 * k -: 8] = SBOX[x[511 - 64 * k - 8 * i -: 8]];
      end
    end
    for (int i = 0; i < 8; i++) begin
      row = '0;
      for (int b = 0; b < 64; b++) begin
        if (t[511 - 64 * i - b]) begin
          row = row ^ LIN[b];
        end
      end
      y[511 - 64 * i -: 64] = row;
    end
    return y;
  endfunction

  function automatic logic [511:0] compress_block(input logic [511:0] h,
                                                  input logic [511:0] n,
                                                  input logic [511:0] m);
    logic [511:0] key;
    logic [511:0] st;
    key = mix_bytes(h ^ n);
    st = m ^ key;
    for (int r = 0; r < 12; r++) begin
      st = mix_bytes(st);
      key = mix_bytes(key ^ KEY_CONST[r]);
      st = st ^ key;
    end
    return h ^ st ^ m;
  endfunction

  task automatic restart_message();
    chain_h = wide_digest ? '0 : {64{8'h01}};
    length_n = '0;
    sum_sigma = '0;
    for (int i = 0; i < 8; i++) word_buf[i] = '0;
    word_pos = '0;
  endtask

  task automatic absorb_word(input in_t beat);
    logic [511:0] blk;
    logic [511:0] mask;
    out_t         w;
    int           count;
    word_buf[word_pos] = beat.data_word;
    word_pos = word_pos + 3'd1;
    if (beat.end_of_block) begin
      for (int i = 0; i < 8; i++) blk[511 - 64 * i -: 64] = word_buf[i];
      for (int i = 0; i < 8; i++) word_buf[i] = '0;
      word_pos = '0;
      if (!beat.final_block) begin
        chain_h = compress_block(chain_h, length_n, blk);
        length_n = length_n + 512'd512;
        sum_sigma = sum_sigma + blk;
      end else begin
        mask = (512'd1 << beat.tail_bits) - 512'd1;
        blk = (blk & mask) | (512'd1 << beat.tail_bits);
        chain_h = compress_block(chain_h, length_n, blk);
        length_n = length_n + 512'(beat.tail_bits);
        sum_sigma = sum_sigma + blk;
        chain_h = compress_block(chain_h, '0, length_n);
        chain_h = compress_block(chain_h, '0, sum_sigma);
        count = wide_digest ? 8 : 4;
        for (int i = 0; i < count; i++) begin
          w.digest_word = chain_h[511 - 64 * i -: 64];
          w.digest_last = (i == count - 1);
          digest_queue.push_back(w);
        end
        restart_message();
      end
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      wide_digest = 1'b1;
      restart_message();
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        wide_digest = cfg_data;
        restart_message();
      end
      if (in_valid && !in_stall) absorb_word(in_data);
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest beat %h last %b", $time,
                   out_data.digest_word, out_data.digest_last);
          fail_count++;
        end else begin
          want = digest_queue.pop_front();
          if (want.digest_word !== out_data.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     want.digest_word, out_data.digest_word);
            fail_count++;
          end
          if (want.digest_last !== out_data.digest_last) begin
            $display("%0t: digest_last expected %b actual %b", $time,
                     want.digest_last, out_data.digest_last);
            fail_count++;
          end
        end
      end
    end
    pending = digest_queue.size();
  end

endmodule

// ===== tb/streebog_hash_engine_unit_test.sv =====
// Testbench top for the Streebog hash engine: clock, reset, message stimulus,
// output stalls, watchdog and verdict. Depends on strb_pkg, the engine and
// streebog_hash_engine_unit_checker.
`timescale 1ns / 1ps
module streebog_hash_engine_unit_test;
  import strb_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int SettleCycles = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   words_sent = 0;
  int   idle_cycles = 0;
  int   out_hold = 0;
  logic steady = 1'b0;

  always #4 clk = ~clk;

  streebog_hash_engine_unit u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  streebog_hash_engine_unit_checker u_check (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_hold = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      out_hold = steady ? 0 : $urandom_range(0, 3);
      out_stall <= (out_hold != 0);
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall <= (out_hold != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_beat(input logic [63:0] data, input logic eob,
                           input logic fin, input logic [8:0] tail);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_word: data, end_of_block: eob, final_block: fin, tail_bits: tail};
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Words before the last carry random flags, which the engine must ignore.
  task automatic send_block(input int words, input logic fin, input logic [8:0] tail);
    for (int i = 0; i < words - 1; i++) begin
      send_beat(rand_word(), 1'b0, 1'($urandom()), 9'($urandom()));
    end
    send_beat(rand_word(), 1'b1, fin, tail);
  endtask

  // The checker updates its count at the edge that takes the last beat, so
  // the task waits for the next edge before the count is read.
  task automatic drain_and_set(input logic wide);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= wide;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int block_words();
    case ($urandom_range(0, 9))
      0: return $urandom_range(1, 7);
      1: return $urandom_range(9, 12);
      default: return 8;
    endcase
  endfunction

  function automatic logic [8:0] rand_tail();
    case ($urandom_range(0, 5))
      0: return 9'd0;
      1: return 9'd511;
      2: return 9'(64 * $urandom_range(0, 7));
      default: return 9'($urandom());
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_block(1, 1'b1, 9'd0);
    send_block(8, 1'b1, 9'd511);
    send_block(8, 1'b0, 9'd0);
    send_block(8, 1'b1, 9'd63);
    send_block(3, 1'b0, 9'd0);
    send_block(2, 1'b1, 9'd64);
    drain_and_set(1'b0);
    send_block(10, 1'b1, 9'd300);
    drain_and_set(1'b1);

    while (words_sent < 280) begin
      steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 2)) send_block(block_words(), 1'b0, 9'($urandom()));
      send_block(block_words(), 1'b1, rand_tail());
      if ($urandom_range(0, 5) == 0) drain_and_set(1'($urandom()));
    end
    steady = 1'b0;
    drain_and_set(1'b0);
    send_block(8, 1'b1, 9'd511);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
